### hw/rtl/chisq_pkg.sv
`default_nettype none

package chisq_pkg;

    localparam int BIN_W    = 16;
    localparam int NUM_W    = 2 * BIN_W;
    localparam int DEN_W    = BIN_W + 1;
    localparam int QUO_W    = BIN_W;
    localparam int SUM_W    = 28;
    localparam int DIST_W   = SUM_W - 1;
    localparam int CNT_W    = 13;
    localparam int STEP_W   = $clog2(QUO_W);

    localparam int MAX_BINS     = 4096;
    localparam int CNT_FIELD_MX = (1 << CNT_W) - 1;
    localparam int CNT_CEIL_I   = (MAX_BINS > CNT_FIELD_MX) ? CNT_FIELD_MX : MAX_BINS;

    localparam logic [CNT_W-1:0]  CNT_CEIL = CNT_CEIL_I[CNT_W-1:0];
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_DIVIDE,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/chisq_div.sv
`default_nettype none

// radix-2 restoring divider, one quotient bit per cycle; needs num < den << QUO_W
module chisq_div import chisq_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [QUO_W-1:0]      o_quo
);

    logic [DEN_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_nq;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    n_part;
    logic              n_ge;
    logic [DEN_W:0]    n_sub;
    logic [DEN_W-1:0]  n_rem;

    always_comb begin
        n_part = {r_rem, r_nq[QUO_W-1]};
        n_ge   = (n_part >= {1'b0, r_den});
        n_sub  = n_part - {1'b0, r_den};
        n_rem  = n_ge ? n_sub[DEN_W-1:0] : n_part[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num[NUM_W-1:QUO_W]};
            r_nq  <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_nq  <= {r_nq[QUO_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_nq;

endmodule

`default_nettype wire

### hw/rtl/chi_square_histogram_distance.sv
// A result follows its last bin request through square, a 16-step shared divider,
// sum and emit; a pair that sums to zero skips the divider.
// No new bin request is taken until the bin in work is through; a last bin also
// waits in the emit step while the output register holds a stalled result.
// A finished result waits in the output register while the next bins stream in.
// Reset (synchronous, active low) clears the sum, count, flag and all valids.
`default_nettype none

module chi_square_histogram_distance import chisq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BIN_W-1:0]  i_bin_a,
    input  wire logic [BIN_W-1:0]  i_bin_b,
    input  wire logic              i_last_bin,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [DIST_W-1:0]      o_distance,
    output logic [CNT_W-1:0]       o_bins_seen,
    output logic                   o_overflowed
);

    t_state            r_state, n_state;
    logic [BIN_W-1:0]  r_diff;
    logic [DEN_W-1:0]  r_den;
    logic              r_last;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_sat;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_distance;
    logic [CNT_W-1:0]  r_bins_seen;
    logic              r_overflowed;

    logic              n_accept;
    logic              n_div_start;
    logic              n_acc_en;
    logic [QUO_W-1:0]  n_term;
    logic              n_load;
    logic [SUM_W:0]    n_sum_wide;
    logic [NUM_W-1:0]  n_square;
    logic              w_div_done;
    logic [QUO_W-1:0]  w_div_quo;

    assign n_accept = i_in_valid && !o_in_stall;
    assign n_square = r_diff * r_diff;

    chisq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (n_square),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_div_start = 1'b0;
        n_acc_en    = 1'b0;
        n_term      = '0;
        n_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SQUARE;
            end
            S_SQUARE: begin
                if (r_den == '0) begin
                    n_acc_en = 1'b1;
                    n_state  = r_last ? S_EMIT : S_IDLE;
                end else begin
                    n_div_start = 1'b1;
                    n_state     = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (w_div_done) begin
                    n_acc_en = 1'b1;
                    n_term   = w_div_quo;
                    n_state  = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_sum_wide = {1'b0, r_sum} + {{(SUM_W + 1 - QUO_W){1'b0}}, n_term};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_acc_en) begin
                if (n_sum_wide[SUM_W]) begin
                    r_sum <= SUM_MAX;
                    r_sat <= 1'b1;
                end else begin
                    r_sum <= n_sum_wide[SUM_W-1:0];
                end
                if (r_cnt < CNT_CEIL) r_cnt <= r_cnt + 1'b1;
            end
            if (n_load) begin
                r_sum       <= '0;
                r_cnt       <= '0;
                r_sat       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_diff <= (i_bin_a >= i_bin_b) ? (i_bin_a - i_bin_b) : (i_bin_b - i_bin_a);
            r_den  <= {1'b0, i_bin_a} + {1'b0, i_bin_b};
            r_last <= i_last_bin;
        end
        if (n_load) begin
            r_distance   <= r_sum[SUM_W-1:1];
            r_bins_seen  <= r_cnt;
            r_overflowed <= r_sat;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_distance   = r_distance;
    assign o_bins_seen  = r_bins_seen;
    assign o_overflowed = r_overflowed;

`ifndef SYNTH
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> o_in_stall)
        else $error("request accepted while a bin is still in work");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside the emit step");

    a_sat_holds_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_sum == SUM_MAX))
        else $error("saturation flag set but sum below ceiling");

    a_cnt_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_CEIL)
        else $error("bin count beyond ceiling");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_div_start |=> (r_state == S_DIVIDE) && !w_div_done)
        else $error("divider launch out of sequence");
`endif

endmodule

`default_nettype wire
